FILE: hdl/hmbd_pkg.sv
`timescale 1ns / 1ps
package hmbd_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] program_counter;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  region;
  } out_item_t;

  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_PRELOAD = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_WIDE = 2'd3;

  localparam logic [3:0] RG_BOOT = 4'd0;
  localparam logic [3:0] RG_WRAM = 4'd1;
  localparam logic [3:0] RG_IRAM = 4'd2;
  localparam logic [3:0] RG_IO   = 4'd3;
  localparam logic [3:0] RG_PAL  = 4'd4;
  localparam logic [3:0] RG_VRAM = 4'd5;
  localparam logic [3:0] RG_OAM  = 4'd6;
  localparam logic [3:0] RG_CART = 4'd7;
  localparam logic [3:0] RG_NONE = 4'd8;

  // read lane source selected in the response stage
  typedef enum logic [2:0] {
    SRC_ZERO = 3'd0,
    SRC_MEM  = 3'd1,
    SRC_LAT  = 3'd2,
    SRC_OPEN = 3'd3
  } src_t;

  typedef struct packed {
    logic        valid;
    src_t        src;
    logic [1:0]  sz;
    logic [1:0]  lane;
    logic [2:0]  mem_sel;
    logic        boot_load;
    logic [31:0] open_data;
    logic [3:0]  region;
  } stage_ctl_t;

  function automatic logic [3:0] region_of(input logic [3:0] page);
    logic [3:0] r;
    case (page)
      4'h0: r = RG_BOOT;
      4'h2: r = RG_WRAM;
      4'h3: r = RG_IRAM;
      4'h4: r = RG_IO;
      4'h5: r = RG_PAL;
      4'h6: r = RG_VRAM;
      4'h7: r = RG_OAM;
      4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD: r = RG_CART;
      default: r = RG_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] lane_of(input logic [31:0] w, input logic [1:0] a,
                                          input logic [1:0] sz);
    logic [31:0] r;
    case (sz)
      SZ_BYTE: r = {24'd0, w[8*a +: 8]};
      SZ_HALF: r = a[1] ? {16'd0, w[31:16]} : {16'd0, w[15:0]};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/hmbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module hmbd_ram #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [3:0]    wr_be,
  input  wire logic [31:0]   wr_data
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if (wr_be[i]) mem[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
      end
    end
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: hdl/handheld_memory_bus_decoder_top.sv
// handheld memory bus decoder
// in_ channel: one bus transaction (read, write or preload byte) as an in_item_t.
// out_ channel: one result per transaction: read data and decoded region.
// cfg_ channel: writes rom_size (cartridge bytes present), clamped to CART_ROM_BYTES.
// the decoded request is registered in s1_r while the stores, which are synchronous
// memories with a registered read port, fetch the word; the read data is then steered
// in a second stage and registered into the output.
// throughput: one transaction per cycle when not stalled. partial writes use per-byte
// lane enables, so no read-modify-write turn is needed and no two accesses collide.
// the boot opcode latch is a register updated in the response stage and
// forwarded to the very next boot read.
// reset clears the pipeline valids, the latch and rom_size; the stores are
// not cleared and hold garbage until written.
// when out_ready is low with a result held the pipeline holds and in_ready drops, so no
// result is lost; in_ready follows out_ready combinationally.
`timescale 1ns / 1ps
`default_nettype none
module handheld_memory_bus_decoder_top #(
  parameter int CART_ROM_BYTES = 8388608
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hmbd_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hmbd_pkg::out_item_t    out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [25:0]       cfg_rom_size
);
  localparam int CART_WORDS = CART_ROM_BYTES / 4;
  localparam int CAW = $clog2(CART_WORDS);

  localparam logic [2:0] M_WRAM = 3'd0;
  localparam logic [2:0] M_IRAM = 3'd1;
  localparam logic [2:0] M_PAL  = 3'd2;
  localparam logic [2:0] M_VRAM = 3'd3;
  localparam logic [2:0] M_OAM  = 3'd4;
  localparam logic [2:0] M_BOOT = 3'd5;
  localparam logic [2:0] M_CART = 3'd6;

  logic [25:0] rom_size_r;
  logic [31:0] latch_r;
  hmbd_pkg::stage_ctl_t s1_r, s1_nxt;
  logic        ov_r;
  hmbd_pkg::out_item_t od_r;
  logic adv;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) rom_size_r <= '0;
    else if (cfg_valid) rom_size_r <= cfg_rom_size;
  end

  assign adv = !ov_r || out_ready;
  assign in_ready = adv;

  // decode stage
  logic [1:0]  sz;
  logic [3:0]  page;
  logic [31:0] a;
  logic [24:0] ca;
  logic [16:0] vo;
  logic [25:0] lim;
  logic        is_rd, is_wr, is_pl, acc;
  logic [6:0]  wen;
  logic [3:0]  be;
  logic [31:0] wd;
  logic [17:0] waddr;
  logic [31:0] half_a, half_a2;

  always_comb begin
    acc = in_valid && adv;
    sz = (in_data.access_size == hmbd_pkg::SZ_WIDE) ? hmbd_pkg::SZ_WORD
                                                     : in_data.access_size;
    page = in_data.address[27:24];
    a = in_data.address;
    if (sz == hmbd_pkg::SZ_HALF) a[0] = 1'b0;
    else if (sz == hmbd_pkg::SZ_WORD) a[1:0] = 2'b00;
    ca = a[24:0];
    vo = a[16:0];
    if (vo >= 17'h18000) vo[15] = 1'b0;
    lim = (rom_size_r > 26'(CART_ROM_BYTES)) ? 26'(CART_ROM_BYTES) : rom_size_r;
    is_rd = in_data.cmd == hmbd_pkg::CMD_READ;
    is_wr = in_data.cmd == hmbd_pkg::CMD_WRITE;
    is_pl = in_data.cmd == hmbd_pkg::CMD_PRELOAD;
    half_a = {8'd0, ca[24:1]};
    half_a2 = 32'({1'b0, ca} + 26'd2) >> 1;

    wen = '0;
    be = '0;
    wd = in_data.write_data;
    waddr = a[19:2];
    case (sz)
      hmbd_pkg::SZ_BYTE: be = 4'b0001 << a[1:0];
      hmbd_pkg::SZ_HALF: be = a[1] ? 4'b1100 : 4'b0011;
      default: be = 4'b1111;
    endcase
    if (sz == hmbd_pkg::SZ_BYTE) wd = {4{in_data.write_data[7:0]}};
    else if (sz == hmbd_pkg::SZ_HALF) wd = {2{in_data.write_data[15:0]}};
    if (is_wr) begin
      case (page)
        4'h2: wen[M_WRAM] = 1'b1;
        4'h3: wen[M_IRAM] = 1'b1;
        4'h5: wen[M_PAL] = 1'b1;
        4'h6: wen[M_VRAM] = vo[16:2] < 15'd24576;
        4'h7: wen[M_OAM] = 1'b1;
        default: ;
      endcase
      if ((page == 4'h5 || page == 4'h6 || page == 4'h7) && sz == hmbd_pkg::SZ_BYTE)
        be = a[1] ? 4'b1100 : 4'b0011;
      if (page == 4'h6) waddr = {3'd0, vo[16:2]};
    end else if (is_pl) begin
      be = 4'b0001 << in_data.address[1:0];
      wd = {4{in_data.write_data[7:0]}};
      if (page == 4'h0 && in_data.address < 32'h4000) begin
        wen[M_BOOT] = 1'b1;
        waddr = {6'd0, in_data.address[13:2]};
      end else if (hmbd_pkg::region_of(page) == hmbd_pkg::RG_CART
                   && {7'd0, in_data.address[24:0]} < 32'(CART_ROM_BYTES)) begin
        wen[M_CART] = 1'b1;
      end
    end
    if (!acc) wen = '0;

    s1_nxt.valid = acc;
    s1_nxt.src = hmbd_pkg::SRC_ZERO;
    s1_nxt.sz = sz;
    s1_nxt.lane = a[1:0];
    s1_nxt.mem_sel = M_WRAM;
    s1_nxt.boot_load = 1'b0;
    s1_nxt.open_data = '0;
    s1_nxt.region = hmbd_pkg::region_of(page);
    if (is_rd) begin
      case (page)
        4'h0: begin
          s1_nxt.mem_sel = M_BOOT;
          if (in_data.program_counter >= 32'h4000) s1_nxt.src = hmbd_pkg::SRC_LAT;
          else begin
            s1_nxt.boot_load = 1'b1;
            if (a < 32'h4000) s1_nxt.src = hmbd_pkg::SRC_MEM;
          end
        end
        4'h2: begin s1_nxt.src = hmbd_pkg::SRC_MEM; s1_nxt.mem_sel = M_WRAM; end
        4'h3: begin s1_nxt.src = hmbd_pkg::SRC_MEM; s1_nxt.mem_sel = M_IRAM; end
        4'h5: begin s1_nxt.src = hmbd_pkg::SRC_MEM; s1_nxt.mem_sel = M_PAL; end
        4'h6: begin
          s1_nxt.mem_sel = M_VRAM;
          if (vo[16:2] < 15'd24576) s1_nxt.src = hmbd_pkg::SRC_MEM;
        end
        4'h7: begin s1_nxt.src = hmbd_pkg::SRC_MEM; s1_nxt.mem_sel = M_OAM; end
        4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD: begin
          s1_nxt.mem_sel = M_CART;
          if (!(page == 4'hD && sz == hmbd_pkg::SZ_HALF)) begin
            if ({1'b0, ca} >= lim) begin
              s1_nxt.src = hmbd_pkg::SRC_OPEN;
              s1_nxt.sz = hmbd_pkg::SZ_WORD;
              case (sz)
                hmbd_pkg::SZ_BYTE: s1_nxt.open_data = {24'd0, half_a[7:0]};
                hmbd_pkg::SZ_HALF: s1_nxt.open_data = {16'd0, half_a[15:0]};
                default: s1_nxt.open_data = {half_a2[15:0], half_a[15:0]};
              endcase
            end else if ({1'b0, ca} < 26'(CART_ROM_BYTES)) begin
              s1_nxt.src = hmbd_pkg::SRC_MEM;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // memories: read port fed straight from the decoded address
  logic [31:0] rd_wram, rd_iram, rd_pal, rd_vram, rd_oam, rd_boot, rd_cart;

  hmbd_ram #(.DEPTH(65536), .AW(16)) u_wram (
    .clk, .rd_en(acc), .rd_addr(a[17:2]), .rd_data(rd_wram),
    .wr_en(wen[M_WRAM]), .wr_addr(a[17:2]), .wr_be(be), .wr_data(wd));
  hmbd_ram #(.DEPTH(8192), .AW(13)) u_iram (
    .clk, .rd_en(acc), .rd_addr(a[14:2]), .rd_data(rd_iram),
    .wr_en(wen[M_IRAM]), .wr_addr(a[14:2]), .wr_be(be), .wr_data(wd));
  hmbd_ram #(.DEPTH(256), .AW(8)) u_pal (
    .clk, .rd_en(acc), .rd_addr(a[9:2]), .rd_data(rd_pal),
    .wr_en(wen[M_PAL]), .wr_addr(a[9:2]), .wr_be(be), .wr_data(wd));
  hmbd_ram #(.DEPTH(24576), .AW(15)) u_vram (
    .clk, .rd_en(acc), .rd_addr(vo[16:2]), .rd_data(rd_vram),
    .wr_en(wen[M_VRAM]), .wr_addr(waddr[14:0]), .wr_be(be), .wr_data(wd));
  hmbd_ram #(.DEPTH(256), .AW(8)) u_oam (
    .clk, .rd_en(acc), .rd_addr(a[9:2]), .rd_data(rd_oam),
    .wr_en(wen[M_OAM]), .wr_addr(a[9:2]), .wr_be(be), .wr_data(wd));
  hmbd_ram #(.DEPTH(4096), .AW(12)) u_boot (
    .clk, .rd_en(acc), .rd_addr(a[13:2]), .rd_data(rd_boot),
    .wr_en(wen[M_BOOT]), .wr_addr(waddr[11:0]), .wr_be(be), .wr_data(wd));
  hmbd_ram #(.DEPTH(CART_WORDS), .AW(CAW)) u_cart (
    .clk, .rd_en(acc), .rd_addr(ca[CAW+1:2]), .rd_data(rd_cart),
    .wr_en(wen[M_CART]), .wr_addr(in_data.address[CAW+1:2]), .wr_be(be), .wr_data(wd));

  always_ff @(posedge clk) begin
    if (!rst_n) s1_r.valid <= 1'b0;
    else if (adv) s1_r <= s1_nxt;
  end

  // response stage
  logic [31:0] mem_word, rd_val, latch_nxt;
  always_comb begin
    case (s1_r.mem_sel)
      M_WRAM: mem_word = rd_wram;
      M_IRAM: mem_word = rd_iram;
      M_PAL:  mem_word = rd_pal;
      M_VRAM: mem_word = rd_vram;
      M_OAM:  mem_word = rd_oam;
      M_BOOT: mem_word = rd_boot;
      M_CART: mem_word = rd_cart;
      default: mem_word = '0;
    endcase
    latch_nxt = latch_r;
    if (s1_r.boot_load)
      latch_nxt = (s1_r.src == hmbd_pkg::SRC_MEM) ? rd_boot : '0;
    case (s1_r.src)
      hmbd_pkg::SRC_MEM:  rd_val = hmbd_pkg::lane_of(mem_word, s1_r.lane, s1_r.sz);
      hmbd_pkg::SRC_LAT:  rd_val = hmbd_pkg::lane_of(latch_r, s1_r.lane, s1_r.sz);
      hmbd_pkg::SRC_OPEN: rd_val = s1_r.open_data;
      default: rd_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      latch_r <= '0;
    end else if (adv) begin
      ov_r <= s1_r.valid;
      if (s1_r.valid) latch_r <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      od_r.read_data <= rd_val;
      od_r.region <= s1_r.region;
    end
  end

  assign out_valid = ov_r;
  assign out_data = od_r;
endmodule
`default_nettype wire
